>>> design/lvn_pkg.sv
// Package for the lattice value noise block: field widths, table sizing,
// item kinds and configuration register indexes. No dependencies.
package lvn_pkg;

  // Table sizing
  localparam int TBL_AW   = 8;
  localparam int MAX_OCT  = 8;

  // Field widths
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 24;
  localparam int REG_W       = 24;
  localparam int SUM_W       = 48;
  localparam int DEN_W       = 27;
  localparam int NOISE_W     = 18;

  // Item kinds carried in tuser
  localparam logic [1:0] KIND_PERM = 2'd0;
  localparam logic [1:0] KIND_VAL  = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FREQ = 2'd0;
  localparam logic [1:0] CFG_AMP  = 2'd1;
  localparam logic [1:0] CFG_LAC  = 2'd2;
  localparam logic [1:0] CFG_PERS = 2'd3;

  // Register reset values, unsigned Q8.16
  localparam logic [REG_W-1:0] FREQ_RST = 24'd65536;
  localparam logic [REG_W-1:0] AMP_RST  = 24'd65536;
  localparam logic [REG_W-1:0] LAC_RST  = 24'd131072;
  localparam logic [REG_W-1:0] PERS_RST = 24'd32768;
  localparam logic [REG_W-1:0] ONE_Q16  = 24'd65536;

endpackage

>>> design/lattice_value_noise_fbm.sv
// Lattice value noise with fractal sum: sequencer, permutation and value memories,
// shared multipliers, a bit-serial divider and an output register. Uses lvn_pkg.
// Per octave: split each of the D axes (D = dimensions), read permutation and value tables, lerp
// and accumulate; a fractal item then divides by the amplitude sum (skipped if it is zero) before
// the output register loads. One item at a time: input is accepted only while the block is idle.
// Reset clears control state and restores register defaults; tables stay undefined until written.
module lattice_value_noise_fbm (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // table_index[7:0], table_entry[16:8], dimensions[18:17], octaves[22:19],
  // coord_x[54:23], coord_y[86:55], coord_z[118:87], zero pad [119]
  input  logic [119:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // noise_value[17:0], zero pad [23:18]
  output logic [23:0]  m_axis_tdata_o,
  // zero_weight[0]
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SPLIT = 4'd1;
  localparam logic [3:0] ST_PERM  = 4'd2;
  localparam logic [3:0] ST_VAL   = 4'd3;
  localparam logic [3:0] ST_LERP  = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_FIN   = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_FIX   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam int TBL_N = 1 << lvn_pkg::TBL_AW;

  // Saturating Q8.16 multiply for the per-octave updates
  function automatic logic [23:0] msat(input logic [23:0] a, input logic [23:0] b);
    logic [47:0] p;
    p = a * b;
    return (|p[47:40]) ? 24'hFFFFFF : p[39:16];
  endfunction

  // Control state
  logic [3:0]  st_q;
  logic [1:0]  ax_q, sub_q, lv_q, pk_q;
  logic [2:0]  pc_q;
  logic [3:0]  vc_q, oc_q;
  logic [5:0]  dc_q;
  logic        out_valid_q;
  logic [23:0] bfreq_q, bamp_q, lac_q, pers_q;

  // Datapath registers
  logic [1:0]  dims_q;
  logic [3:0]  oct_q;
  logic [31:0] cx_q, cy_q, cz_q;
  logic [23:0] freq_q, amp_q;
  logic [7:0]  cell_q [3];
  logic [15:0] r_q;
  logic [31:0] rr_q;
  logic [15:0] sm_q [3];
  logic [7:0]  pb_q [6];
  logic signed [17:0] v_q [8];
  logic signed [47:0] sum_q;
  logic [26:0] den_q;
  logic        neg_q;
  logic [27:0] rem_q;
  logic [47:0] quo_q;
  logic [17:0] res_q;
  logic        zw_q;
  logic [17:0] out_res_q;
  logic        out_zw_q;

  // Memories
  logic [7:0]  perm_mem [TBL_N];
  logic [8:0]  val_mem  [TBL_N];
  logic [7:0]  p_addr, v_addr, p_rd_q;
  logic [8:0]  v_rd_q;

  // Input field views
  logic [7:0]  in_idx;
  logic [8:0]  in_entry;
  logic [1:0]  in_dims;
  logic [3:0]  in_oct;
  assign in_idx   = s_axis_tdata_i[7:0];
  assign in_entry = s_axis_tdata_i[16:8];
  assign in_dims  = s_axis_tdata_i[18:17];
  assign in_oct   = s_axis_tdata_i[22:19];

  logic s_fire, m_fire, hand_off;
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = out_valid_q && m_axis_tready_i;
  assign hand_off        = (st_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);
  assign cfg_ready_o     = 1'b1;

  // Coordinate split: scale by frequency, take cell and fraction
  logic [31:0]        coord_sel;
  logic signed [56:0] cprod;
  logic [17:0]        tpoly;
  logic [49:0]        smp;
  logic [31:0]        rr_d;
  assign coord_sel = (ax_q == 2'd0) ? cx_q : ((ax_q == 2'd1) ? cy_q : cz_q);
  assign cprod     = $signed(coord_sel) * $signed({1'b0, freq_q});
  assign rr_d      = r_q * r_q;
  assign tpoly     = 18'd196608 - {1'b0, r_q, 1'b0};
  assign smp       = rr_q * tpoly;

  // Permutation read address: two corner hashes, then four row hashes
  logic [2:0] pn;
  assign pn     = (dims_q == 2'd1) ? 3'd2 : 3'd6;
  assign p_addr = (pc_q < 3'd2) ? (cell_q[0] + {7'd0, pc_q[0]})
                : (pb_q[{2'd0, pc_q[0]}] + cell_q[1] + {7'd0, pc_q[2]});

  // Value read address
  logic [3:0] vn;
  logic [2:0] vk, pc_m1, vc_m1w;
  logic [3:0] vc_m1;
  logic [7:0] v_base, v_zoff;
  assign vn     = (dims_q == 2'd1) ? 4'd2 : ((dims_q == 2'd2) ? 4'd4 : 4'd8);
  assign vk     = vc_q[2:0];
  assign v_base = (dims_q == 2'd1) ? pb_q[{2'd0, vk[0]}] : pb_q[3'd2 + {1'b0, vk[1:0]}];
  assign v_zoff = (dims_q == 2'd3) ? (cell_q[2] + {7'd0, vk[2]}) : 8'd0;
  assign v_addr = v_base + v_zoff;
  assign pc_m1  = pc_q - 3'd1;
  assign vc_m1  = vc_q - 4'd1;
  assign vc_m1w = vc_m1[2:0];

  // Shared lerp unit
  logic signed [17:0] la, lb;
  logic signed [18:0] ldiff;
  logic signed [35:0] lprod;
  logic signed [19:0] lres;
  logic [1:0]         lv_rem, pk_last;
  assign la      = v_q[{pk_q, 1'b0}];
  assign lb      = v_q[{pk_q, 1'b1}];
  assign ldiff   = {lb[17], lb} - {la[17], la};
  assign lprod   = $signed({1'b0, sm_q[lv_q]}) * ldiff;
  assign lres    = {{2{la[17]}}, la} + lprod[35:16];
  assign lv_rem  = dims_q - 2'd1 - lv_q;
  assign pk_last = (lv_rem == 2'd2) ? 2'd3 : ((lv_rem == 2'd1) ? 2'd1 : 2'd0);

  // Octave accumulate
  logic signed [42:0] aprod;
  assign aprod = $signed({1'b0, amp_q}) * v_q[0];

  // Divider step
  logic [27:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q[26:0], quo_q[47]};
  assign q_bit  = (rem_sh >= {1'b0, den_q});

  // Final saturation
  logic [17:0] mag;
  assign mag = (quo_q > 48'd65536) ? 18'd65536 : quo_q[17:0];

  // Table writes and synchronous reads
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser_i == lvn_pkg::KIND_PERM) begin
      perm_mem[in_idx] <= in_entry[7:0];
    end
    if (s_fire && s_axis_tuser_i == lvn_pkg::KIND_VAL) begin
      val_mem[in_idx] <= in_entry;
    end
    p_rd_q <= perm_mem[p_addr];
    v_rd_q <= val_mem[v_addr];
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ax_q        <= 2'd0;
      sub_q       <= 2'd0;
      pc_q        <= 3'd0;
      vc_q        <= 4'd0;
      lv_q        <= 2'd0;
      pk_q        <= 2'd0;
      oc_q        <= 4'd0;
      dc_q        <= 6'd0;
      out_valid_q <= 1'b0;
      bfreq_q     <= lvn_pkg::FREQ_RST;
      bamp_q      <= lvn_pkg::AMP_RST;
      lac_q       <= lvn_pkg::LAC_RST;
      pers_q      <= lvn_pkg::PERS_RST;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lvn_pkg::CFG_FREQ: bfreq_q <= cfg_data_i;
          lvn_pkg::CFG_AMP:  bamp_q  <= cfg_data_i;
          lvn_pkg::CFG_LAC:  lac_q   <= cfg_data_i;
          lvn_pkg::CFG_PERS: pers_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // Load the output register on hand-off, drop it after the transfer
      if (hand_off) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (s_fire && s_axis_tuser_i == lvn_pkg::KIND_EVAL) begin
            ax_q  <= 2'd0;
            sub_q <= 2'd0;
            oc_q  <= 4'd0;
            st_q  <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (sub_q == 2'd2) begin
            sub_q <= 2'd0;
            if (ax_q == dims_q - 2'd1) begin
              pc_q <= 3'd0;
              st_q <= ST_PERM;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end else begin
            sub_q <= sub_q + 2'd1;
          end
        end
        ST_PERM: begin
          if (pc_q == pn) begin
            vc_q <= 4'd0;
            st_q <= ST_VAL;
          end else begin
            pc_q <= pc_q + 3'd1;
          end
        end
        ST_VAL: begin
          if (vc_q == vn) begin
            lv_q <= 2'd0;
            pk_q <= 2'd0;
            st_q <= ST_LERP;
          end else begin
            vc_q <= vc_q + 4'd1;
          end
        end
        ST_LERP: begin
          if (pk_q == pk_last) begin
            pk_q <= 2'd0;
            if (lv_q == dims_q - 2'd1) begin
              st_q <= ST_ACC;
            end else begin
              lv_q <= lv_q + 2'd1;
            end
          end else begin
            pk_q <= pk_q + 2'd1;
          end
        end
        ST_ACC: begin
          if (oct_q == 4'd0) begin
            st_q <= ST_DONE;
          end else begin
            oc_q <= oc_q + 4'd1;
            if (oc_q + 4'd1 == oct_q) begin
              st_q <= ST_FIN;
            end else begin
              ax_q  <= 2'd0;
              sub_q <= 2'd0;
              st_q  <= ST_SPLIT;
            end
          end
        end
        ST_FIN: begin
          dc_q <= 6'd0;
          st_q <= (den_q == 27'd0) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          dc_q <= dc_q + 6'd1;
          if (dc_q == 6'd47) begin
            st_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          st_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (hand_off) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (s_fire && s_axis_tuser_i == lvn_pkg::KIND_EVAL) begin
          dims_q <= (in_dims == 2'd0) ? 2'd1 : in_dims;
          oct_q  <= (in_oct > 4'(lvn_pkg::MAX_OCT)) ? 4'(lvn_pkg::MAX_OCT) : in_oct;
          cx_q   <= s_axis_tdata_i[54:23];
          cy_q   <= s_axis_tdata_i[86:55];
          cz_q   <= s_axis_tdata_i[118:87];
          freq_q <= (in_oct == 4'd0) ? lvn_pkg::ONE_Q16 : bfreq_q;
          amp_q  <= bamp_q;
          sum_q  <= '0;
          den_q  <= '0;
        end
      end
      ST_SPLIT: begin
        case (sub_q)
          2'd0: begin
            cell_q[ax_q] <= cprod[39:32];
            r_q          <= cprod[31:16];
          end
          2'd1: rr_q <= rr_d;
          default: sm_q[ax_q] <= smp[47:32];
        endcase
      end
      ST_PERM: begin
        if (pc_q != 3'd0) begin
          pb_q[pc_m1] <= p_rd_q;
        end
      end
      ST_VAL: begin
        if (vc_q != 4'd0) begin
          v_q[vc_m1w] <= {v_rd_q[8], v_rd_q, 8'd0};
        end
      end
      ST_LERP: begin
        v_q[{1'b0, pk_q}] <= lres[17:0];
      end
      ST_ACC: begin
        if (oct_q == 4'd0) begin
          res_q <= v_q[0];
          zw_q  <= 1'b0;
        end else begin
          sum_q  <= sum_q + {{5{aprod[42]}}, aprod};
          den_q  <= den_q + {3'd0, amp_q};
          freq_q <= msat(freq_q, lac_q);
          amp_q  <= msat(amp_q, pers_q);
        end
      end
      ST_FIN: begin
        res_q <= '0;
        zw_q  <= (den_q == 27'd0);
        neg_q <= sum_q[47];
        rem_q <= '0;
        quo_q <= sum_q[47] ? (48'd0 - sum_q) : sum_q;
      end
      ST_DIV: begin
        rem_q <= q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quo_q <= {quo_q[46:0], q_bit};
      end
      ST_FIX: begin
        res_q <= neg_q ? (18'd0 - mag) : mag;
      end
      default: ;
    endcase
  end

  // Output register, loaded on hand-off
  always_ff @(posedge clk_i) begin
    if (hand_off) begin
      out_res_q <= res_q;
      out_zw_q  <= zw_q;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {6'd0, out_res_q};
  assign m_axis_tuser_o[0] = out_zw_q;

  // Result hand-off and value checks
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && !out_valid_q) |=> out_valid_q)
    else $error("result not loaded into output register");
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[17:0] == 18'd0))
    else $error("zero weight with nonzero value");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[17:0]) <= 18'sd65536 &&
                         $signed(m_axis_tdata_o[17:0]) >= -18'sd65536))
    else $error("result out of range");
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (den_q != 27'd0))
    else $error("divider running on zero amplitude sum");

endmodule

>>> dv/tb_lattice_value_noise_fbm.sv
// Testbench for lattice_value_noise_fbm: fills both tables, then runs directed and random
// evaluate items under several register settings. Depends on lvn_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef struct {
  bit [lvn_pkg::NOISE_W-1:0] noise;
  bit                        zero_flag;
} noise_result_t;

// Predicts each evaluate item and checks the block's results in order
class noise_scoreboard;
  bit [7:0]                perm_tbl [256];
  int                      value_tbl [256];
  bit [lvn_pkg::REG_W-1:0] freq_reg, amp_reg, lac_reg, pers_reg;
  noise_result_t           pending_results [$];
  int                      error_count;
  int                      eval_count, result_count;

  function new();
    freq_reg = lvn_pkg::FREQ_RST;
    amp_reg  = lvn_pkg::AMP_RST;
    lac_reg  = lvn_pkg::LAC_RST;
    pers_reg = lvn_pkg::PERS_RST;
  endfunction

  function void write_reg(bit [1:0] idx, bit [lvn_pkg::REG_W-1:0] data);
    case (idx)
      lvn_pkg::CFG_FREQ: freq_reg = data;
      lvn_pkg::CFG_AMP:  amp_reg  = data;
      lvn_pkg::CFG_LAC:  lac_reg  = data;
      default:           pers_reg = data;
    endcase
  endfunction

  // Split a scaled coordinate into cell, next cell and smoothed fraction
  function void split_axis(bit [63:0] coord, bit [63:0] freq, output bit [7:0] c0,
                           output bit [7:0] c1, output longint smooth);
    bit [63:0] scaled, frac;
    scaled = (coord * freq) >> 16;
    frac   = scaled[15:0];
    c0     = scaled[23:16];
    c1     = c0 + 8'd1;
    smooth = longint'((frac * frac * (64'd196608 - 2 * frac)) >> 32);
  endfunction

  function longint blend(longint s, longint a, longint b);
    return a + ((s * (b - a)) >>> 16);
  endfunction

  function longint lookup(bit [7:0] idx);
    return longint'(value_tbl[idx]) * 256;
  endfunction

  function longint lattice_noise(int dims, bit [63:0] co [3], bit [63:0] freq);
    bit [7:0] x0, x1, y0, y1, z0, z1, i, j, b00, b10, b01, b11;
    longint sx, sy, sz, near_z, far_z;
    split_axis(co[0], freq, x0, x1, sx);
    i = perm_tbl[x0];
    j = perm_tbl[x1];
    if (dims == 1) return blend(sx, lookup(i), lookup(j));
    split_axis(co[1], freq, y0, y1, sy);
    b00 = perm_tbl[i + y0];
    b10 = perm_tbl[j + y0];
    b01 = perm_tbl[i + y1];
    b11 = perm_tbl[j + y1];
    if (dims == 2)
      return blend(sy, blend(sx, lookup(b00), lookup(b10)),
                   blend(sx, lookup(b01), lookup(b11)));
    split_axis(co[2], freq, z0, z1, sz);
    near_z = blend(sy, blend(sx, lookup(b00 + z0), lookup(b10 + z0)),
                   blend(sx, lookup(b01 + z0), lookup(b11 + z0)));
    far_z  = blend(sy, blend(sx, lookup(b00 + z1), lookup(b10 + z1)),
                   blend(sx, lookup(b01 + z1), lookup(b11 + z1)));
    return blend(sz, near_z, far_z);
  endfunction

  function bit [63:0] scale_sat(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    r = (a * b) >> 16;
    return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
  endfunction

  // Note an accepted input transfer: update the tables or queue a prediction
  function void note_transfer(bit [1:0] kind, bit [lvn_pkg::IN_TDATA_W-1:0] d);
    bit [63:0]     co [3];
    bit [63:0]     freq, amp;
    int            dims, oct;
    longint        acc, denom, res;
    noise_result_t exp_r;
    if (kind == lvn_pkg::KIND_PERM) begin
      perm_tbl[d[7:0]] = d[15:8];
      return;
    end
    if (kind == lvn_pkg::KIND_VAL) begin
      value_tbl[d[7:0]] = int'($signed(d[16:8]));
      return;
    end
    if (kind != lvn_pkg::KIND_EVAL) return;
    eval_count++;
    dims = (d[18:17] == 0) ? 1 : d[18:17];
    oct  = (d[22:19] > lvn_pkg::MAX_OCT) ? lvn_pkg::MAX_OCT : d[22:19];
    co[0] = longint'($signed(d[54:23]));
    co[1] = longint'($signed(d[86:55]));
    co[2] = longint'($signed(d[118:87]));
    exp_r.zero_flag = 0;
    if (oct == 0) begin
      res = lattice_noise(dims, co, 64'd65536);
    end else begin
      freq = freq_reg;
      amp  = amp_reg;
      acc = 0;
      denom = 0;
      for (int k = 0; k < oct; k++) begin
        acc   += longint'(amp) * lattice_noise(dims, co, freq);
        denom += longint'(amp);
        freq = scale_sat(freq, lac_reg);
        amp  = scale_sat(amp, pers_reg);
      end
      if (denom == 0) begin
        res = 0;
        exp_r.zero_flag = 1;
      end else begin
        res = acc / denom;
      end
    end
    if (res > 65536) res = 65536;
    if (res < -65536) res = -65536;
    exp_r.noise = res[lvn_pkg::NOISE_W-1:0];
    pending_results.push_back(exp_r);
  endfunction

  // Compare one output transfer with the oldest prediction
  function void check_result(bit [lvn_pkg::OUT_TDATA_W-1:0] d, bit zero_flag);
    noise_result_t exp_r;
    result_count++;
    if (pending_results.size() == 0) begin
      $error("unexpected result noise_value=%0d", $signed(d[lvn_pkg::NOISE_W-1:0]));
      error_count++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (d[lvn_pkg::NOISE_W-1:0] !== exp_r.noise) begin
      $error("noise_value expected %0d actual %0d", $signed(exp_r.noise),
             $signed(d[lvn_pkg::NOISE_W-1:0]));
      error_count++;
    end
    if (zero_flag !== exp_r.zero_flag) begin
      $error("zero_weight expected %0d actual %0d", exp_r.zero_flag, zero_flag);
      error_count++;
    end
  endfunction
endclass

module tb_lattice_value_noise_fbm;
  localparam int IDLE_LIMIT = 10000;
  localparam int DRAIN_WAIT = 400;

  logic                            clk_i = 0;
  logic                            rst_ni = 0;
  logic                            s_axis_tvalid_i = 0;
  logic                            s_axis_tready_o;
  logic [lvn_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]                      s_axis_tuser_i = lvn_pkg::KIND_EVAL;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 0;
  logic [lvn_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [0:0]                      m_axis_tuser_o;
  logic                            cfg_valid_i = 0;
  logic                            cfg_ready_o;
  logic [1:0]                      cfg_index_i = lvn_pkg::CFG_FREQ;
  logic [lvn_pkg::REG_W-1:0]       cfg_data_i = '0;

  noise_scoreboard sb = new();
  int  burst_left = 0;
  bit  steady_sender = 0;
  bit  long_hold = 0;
  int  idle_cycles = 0;

  lattice_value_noise_fbm dut (.*);

  always #5 clk_i = ~clk_i;

  // Observe transfers on both streams
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) sb.note_transfer(s_axis_tuser_i, s_axis_tdata_i);
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o[0]);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: alternate between free-running and random stalls, with one long hold
  initial begin
    int mode_left;
    bit stall_mode;
    mode_left = 0;
    stall_mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready_i <= 0;
        repeat (3000) @(posedge clk_i);
        long_hold = 0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(50, 300);
          stall_mode = ~stall_mode;
        end
        mode_left--;
        m_axis_tready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
    end
  end

  // Offer one item, with bursts and random gaps between them
  task automatic send_item(input logic [1:0] kind, input logic [lvn_pkg::IN_TDATA_W-1:0] d);
    if (!steady_sender && burst_left == 0) begin
      s_axis_tvalid_i <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_load(input logic [1:0] kind, input bit [7:0] idx, input bit [8:0] entry);
    logic [lvn_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[7:0]  = idx;
    d[16:8] = entry;
    d[118:17] = 102'({$urandom, $urandom, $urandom, $urandom});
    send_item(kind, d);
  endtask

  task automatic send_eval(input bit [1:0] dims, input bit [3:0] oct,
                           input bit [31:0] x, input bit [31:0] y, input bit [31:0] z);
    send_item(lvn_pkg::KIND_EVAL, {1'b0, z, y, x, oct, dims, 9'($urandom), 8'($urandom)});
  endtask

  // Wait until every result is in and the block has gone quiet
  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Offer one register write; the caller drops valid after the last one
  task automatic write_cfg(input bit [1:0] idx, input bit [lvn_pkg::REG_W-1:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Random evaluate coordinate: small, edge or fully random
  function automatic bit [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    bit [lvn_pkg::REG_W-1:0] settings [6][4];
    bit [3:0] oct;
    settings = '{
      '{24'd65536, 24'd65536, 24'd131072, 24'd32768},
      '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
      '{24'd0, 24'd65536, 24'd0, 24'd65536},
      '{24'd65536, 24'd0, 24'd131072, 24'd32768},
      '{24'd3000, 24'd1, 24'd200000, 24'd0},
      '{24'd98304, 24'd40000, 24'd140000, 24'd45000}};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Fill both tables before any lookup
    for (int k = 0; k < 256; k++)
      send_load(lvn_pkg::KIND_PERM, 8'(k), 9'($urandom_range(0, 511)));
    for (int k = 0; k < 256; k++) send_load(lvn_pkg::KIND_VAL, 8'(k), 9'($urandom));

    // Directed: table and field extremes, clamping, ignored kind
    send_load(lvn_pkg::KIND_VAL, 8'd0, 9'h100);
    send_load(lvn_pkg::KIND_VAL, 8'd255, 9'h0FF);
    send_load(lvn_pkg::KIND_PERM, 8'd255, 9'h1FF);
    send_item(2'd3, {lvn_pkg::IN_TDATA_W{1'b1}});
    send_eval(2'd0, 4'd0, 32'h0001_8000, 32'd0, 32'd0);
    send_eval(2'd1, 4'd0, 32'h8000_0000, 32'd0, 32'd0);
    send_eval(2'd1, 4'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_eval(2'd2, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'd0);
    send_eval(2'd3, 4'd0, 32'h00FF_C000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_eval(2'd3, 4'd1, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_4000);
    send_eval(2'd3, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_eval(2'd2, 4'd9, 32'h0003_2000, 32'h0007_E000, 32'd0);
    send_eval(2'd1, 4'd15, 32'h8000_0001, 32'd0, 32'd0);

    // Pause the sender until the block is empty
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) drain();
      for (int r = 0; r < 4; r++) write_cfg(r[1:0], settings[p][r]);
      cfg_valid_i <= 0;
      steady_sender = (p == 2);
      if (p == 1) long_hold = 1;
      for (int n = 0; n < 14; n++) begin
        case ($urandom_range(0, 19))
          0, 1: send_load(lvn_pkg::KIND_VAL, 8'($urandom), 9'($urandom));
          2, 3: send_load(lvn_pkg::KIND_PERM, 8'($urandom), 9'($urandom));
          4: send_item(2'd3, {1'b0, 119'({$urandom, $urandom, $urandom, $urandom})});
          default: begin
            oct = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            send_eval(2'($urandom), oct, rand_coord(), rand_coord(), rand_coord());
          end
        endcase
      end
    end

    drain();
    $display("Covered %0d evaluate items and %0d results over 6 register settings,",
             sb.eval_count, sb.result_count);
    $display("with table rewrites, ignored items, bursty input and stalled output.");
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
